// ===== design/assert_macros.svh =====
// Assertion macros shared by the arccosine block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/pa_pkg.sv =====
// Constants, types and the square-root step for the arccosine block.
// No dependencies.
package pa_pkg;

  localparam int FRAC_BITS = 14;
  localparam int WQ        = 30;
  localparam int SH        = WQ - FRAC_BITS;
  localparam int SQ_W      = 2 * WQ + 4;
  localparam int SQ_CYCLES = (WQ + 2) / 2;
  localparam int CNT_W     = $clog2(SQ_CYCLES);

  localparam logic [WQ:0] ONE_Q = (WQ+1)'(64'd1 << WQ);
  localparam logic [WQ:0] KC3 = (WQ+1)'(((64'd187293 << WQ) + 64'd5000000) / 64'd10000000);
  localparam logic [WQ:0] KC2 = (WQ+1)'(((64'd742610 << WQ) + 64'd5000000) / 64'd10000000);
  localparam logic [WQ:0] KC1 = (WQ+1)'(((64'd2121144 << WQ) + 64'd5000000) / 64'd10000000);
  localparam logic [WQ:0] KC0 = (WQ+1)'(((64'd15707288 << WQ) + 64'd5000000) / 64'd10000000);
  localparam logic [31:0] KPI = 32'd3373259426;

  localparam logic [32:0] RND = (SH == 0) ? 33'd0 : 33'(64'd1 << (SH - 1));
  localparam logic [SQ_W-1:0] SQ_BIT0 = SQ_W'(1) << (2 * WQ + 2);

  // Horner step codes
  localparam logic [1:0] H_C3 = 2'd0;
  localparam logic [1:0] H_C2 = 2'd1;
  localparam logic [1:0] H_C1 = 2'd2;
  localparam logic [1:0] H_C0 = 2'd3;

  typedef struct packed {
    logic       load;
    logic       sqrt_step;
    logic       horner_en;
    logic [1:0] horner_idx;
    logic       final_mul;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
    logic [SQ_W-1:0] bit_v;
  } sq_t;

  function automatic sq_t sqrt_iter(sq_t s);
    sq_t             o;
    logic [SQ_W-1:0] trial;
    o = s;
    trial = s.root + s.bit_v;
    if (s.rem >= trial) begin
      o.rem  = s.rem - trial;
      o.root = (s.root >> 1) + s.bit_v;
    end else begin
      o.root = s.root >> 1;
    end
    o.bit_v = s.bit_v >> 2;
    return o;
  endfunction

endpackage

// ===== design/pa_ctrl.sv =====
// Sequencer for the arccosine block: request acceptance and step commands.
// Depends on pa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output pa_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_FMUL = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t                   state, state_next;
  logic [pa_pkg::CNT_W-1:0] cnt;
  logic                     cnt_last;

  assign busy     = (state != S_IDLE);
  assign cnt_last = (cnt == pa_pkg::CNT_W'(pa_pkg::SQ_CYCLES - 1));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_RUN;
      S_RUN:  if (cnt_last) state_next = S_FMUL;
      S_FMUL: state_next = S_FIN;
      S_FIN:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_RUN) cnt <= cnt_last ? '0 : cnt + 1'b1;
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.load       = start && !busy;
    cmd.sqrt_step  = (state == S_RUN);
    cmd.horner_en  = (state == S_RUN) && (cnt < pa_pkg::CNT_W'(4));
    cmd.horner_idx = cnt[1:0];
    cmd.final_mul  = (state == S_FMUL);
    cmd.finish     = (state == S_FIN);
  end

  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ASSERT_ALWAYS(a_cnt_run, clk, rst, (cnt == '0) || (state == S_RUN))
  `ASSERT_NEXT(a_fmul_fin, clk, rst, cmd.final_mul, cmd.finish)

endmodule

// ===== design/pa_dp.sv =====
// Datapath for the arccosine block: Horner cubic on one shared multiplier,
// two-step-per-cycle square root, final product, rounding. Depends on pa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pa_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic signed [15:0]  x_in,
  input  pa_pkg::cmd_t        cmd,
  output logic                done,
  output logic [15:0]         angle_out
);

  localparam int W = pa_pkg::WQ + 1;

  logic [16:0]          mag;
  logic [W-1:0]         mag_w, a_in;
  logic [W-1:0]         a, p;
  logic                 neg;
  pa_pkg::sq_t          sq, sq_next;
  logic [2*W-1:0]       prod;
  logic [W-1:0]         mq, op_t, mul_a, mul_b;
  logic [31:0]          r;
  logic [32:0]          rsum, res;

  // |x| saturated to one, then aligned to Q30
  always_comb begin
    mag   = x_in[15] ? (17'h10000 - {1'b0, x_in}) : {1'b0, x_in};
    mag_w = W'(mag);
    if (mag_w > (W'(1) << pa_pkg::FRAC_BITS)) mag_w = W'(1) << pa_pkg::FRAC_BITS;
    a_in  = mag_w << pa_pkg::SH;
  end

  assign mq = prod[pa_pkg::WQ +: W];

  always_comb begin
    case (cmd.horner_idx)
      pa_pkg::H_C3: op_t = pa_pkg::KC3;
      pa_pkg::H_C2: op_t = pa_pkg::KC2 - mq;
      pa_pkg::H_C1: op_t = pa_pkg::KC1 - mq;
      pa_pkg::H_C0: op_t = pa_pkg::KC0 - mq;
      default:      op_t = '0;
    endcase
    mul_a = cmd.final_mul ? p : op_t;
    mul_b = cmd.final_mul ? sq.root[W-1:0] : a;
  end

  assign sq_next = pa_pkg::sqrt_iter(pa_pkg::sqrt_iter(sq));

  always_comb begin
    r    = neg ? (pa_pkg::KPI - {1'b0, mq}) : {1'b0, mq};
    rsum = {1'b0, r} + pa_pkg::RND;
    res  = rsum >> pa_pkg::SH;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a           <= a_in;
      neg         <= x_in[15];
      sq.rem      <= pa_pkg::SQ_W'(pa_pkg::ONE_Q - a_in) << pa_pkg::WQ;
      sq.root     <= '0;
      sq.bit_v    <= pa_pkg::SQ_BIT0;
    end else if (cmd.sqrt_step) begin
      sq <= sq_next;
    end
    if (cmd.horner_en && cmd.horner_idx == pa_pkg::H_C0) p <= op_t;
    if ((cmd.horner_en && cmd.horner_idx != pa_pkg::H_C0) || cmd.final_mul)
      prod <= mul_a * mul_b;
    if (cmd.finish) angle_out <= (res > 33'hFFFF) ? 16'hFFFF : res[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= cmd.finish;
  end

  `ASSERT_ALWAYS(a_done_src, clk, rst, !done || $past(cmd.finish))
  `ASSERT_ALWAYS(a_no_overlap, clk, rst, !(cmd.final_mul && cmd.sqrt_step))
  `ASSERT_ALWAYS(a_root_fits, clk, rst, !cmd.final_mul || ((sq.root >> W) == '0))

endmodule

// ===== design/polynomial_arccosine.sv =====
// Arccosine of a Q2.14 cosine value, unsigned Q2.14 angle out.
// Requests do not overlap: busy stays high after acceptance through the square-root
// loop (two root bits a cycle), the final multiply and the rounding step.
// Reset: synchronous, active high; clears the sequencer and the done strobe.
// done marks angle_out for one cycle; the receiver cannot stall.
module polynomial_arccosine (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] x_in,
  output logic               done,
  output logic [15:0]        angle_out
);

  pa_pkg::cmd_t cmd;

  pa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  pa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .x_in      (x_in),
    .cmd       (cmd),
    .done      (done),
    .angle_out (angle_out)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for polynomial_arccosine: directed and random cosine
// requests, each angle checked against a bit-exact Q30 arccosine predictor.
// Depends on design/pa_pkg.sv and design/polynomial_arccosine.sv.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC       = pa_pkg::FRAC_BITS;
  localparam int QW         = 30;
  localparam int SHIFT      = QW - FRAC;
  localparam int N_RANDOM   = 1230;
  localparam int QUIET_TAIL = 150;

  localparam logic [63:0] Q_ONE  = 64'd1 << QW;
  localparam logic [63:0] C_CUBE = ((64'd187293 << QW) + 64'd5000000) / 64'd10000000;
  localparam logic [63:0] C_SQR  = ((64'd742610 << QW) + 64'd5000000) / 64'd10000000;
  localparam logic [63:0] C_LIN  = ((64'd2121144 << QW) + 64'd5000000) / 64'd10000000;
  localparam logic [63:0] C_CON  = ((64'd15707288 << QW) + 64'd5000000) / 64'd10000000;
  localparam logic [63:0] PI_Q   = 64'd3373259426;

  typedef struct {
    logic signed [15:0] x;
    logic [15:0]        angle;
  } angle_req_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic signed [15:0] x_in = '0;
  logic               busy;
  logic               done;
  logic [15:0]        angle_out;

  logic signed [15:0] cosine_queue[$];
  angle_req_t         angle_expect[$];
  int                 errors = 0;
  int                 issued = 0;
  int                 total_reqs = 0;
  int                 idle_left = 0;
  bit                 taken = 1'b0;

  polynomial_arccosine i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .x_in      (x_in),
    .done      (done),
    .angle_out (angle_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  function automatic logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
    return (a * b) >> QW;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [15:0] arccos_angle(logic signed [15:0] x);
    logic [63:0] raw;
    logic [63:0] mag;
    logic [63:0] a;
    logic [63:0] t;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] prod;
    logic [63:0] r;
    logic [63:0] res;
    logic        neg;
    raw = {48'd0, x};
    neg = x[15];
    mag = neg ? (64'h10000 - raw) : raw;
    if (mag > (64'd1 << FRAC)) mag = 64'd1 << FRAC;
    a = mag << SHIFT;
    t = C_SQR - mul_q30(C_CUBE, a);
    t = C_LIN - mul_q30(t, a);
    p = C_CON - mul_q30(t, a);
    s = root_floor((Q_ONE - a) << QW);
    prod = mul_q30(p, s);
    r = neg ? (PI_Q - prod) : prod;
    if (SHIFT == 0) res = r;
    else res = (r + (64'd1 << (SHIFT - 1))) >> SHIFT;
    if (res > 64'hFFFF) res = 64'hFFFF;
    return res[15:0];
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    $display("%0t ERROR: %s", $realtime, msg);
  endtask

  // request list
  initial begin
    logic signed [15:0] directed[22];
    int sel;
    directed = '{16'sd0, 16'sd16384, -16'sd16384, 16'sd16383,
                 -16'sd16383, 16'sd1, -16'sd1, 16'sd16385,
                 -16'sd16385, 16'sd32767, -16'sd32768, -16'sd32767,
                 16'sd8192, -16'sd8192, 16'sd11585, -16'sd11585,
                 16'sd16380, -16'sd16380, 16'sd4, -16'sd4,
                 16'sh5555, 16'shAAAA};
    foreach (directed[i]) cosine_queue.push_back(directed[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      sel = $urandom_range(99);
      if (sel < 70) cosine_queue.push_back(16'($urandom_range(32768) - 16384));
      else if (sel < 80) cosine_queue.push_back(16'($urandom_range(16384, 16300)));
      else if (sel < 88) cosine_queue.push_back(16'(-$urandom_range(16384, 16300)));
      else if (sel < 92) cosine_queue.push_back(16'($urandom_range(64) - 32));
      else cosine_queue.push_back(16'($urandom));
    end
    total_reqs = cosine_queue.size();
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && !taken)) begin
      if (taken) begin
        void'(cosine_queue.pop_front());
        issued++;
      end
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (cosine_queue.size() == 0) begin
        start <= 1'b0;
      end else if ((issued == 22 || issued == total_reqs / 2) && angle_expect.size() != 0) begin
        start <= 1'b0;
      end else if (issued < total_reqs - QUIET_TAIL && $urandom_range(3) == 0) begin
        idle_left = $urandom_range(8);
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        x_in  <= cosine_queue[0];
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    angle_req_t e;
    if (done) begin
      if (angle_expect.size() == 0) begin
        report_mismatch($sformatf("unexpected angle %0d", angle_out));
      end else begin
        e = angle_expect.pop_front();
        if (angle_out !== e.angle)
          report_mismatch($sformatf("x=%0d angle %0d, want %0d", e.x, angle_out, e.angle));
      end
    end
    taken = !rst && start && !busy;
    if (taken) begin
      e.x     = x_in;
      e.angle = arccos_angle(x_in);
      angle_expect.push_back(e);
    end
  end

  initial begin
    @(negedge rst);
    @(posedge clk);
    while (cosine_queue.size() != 0 || start || angle_expect.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== polynomial_arccosine.f =====
+incdir+design
design/pa_pkg.sv
design/pa_ctrl.sv
design/pa_dp.sv
design/polynomial_arccosine.sv
tb/tb_top.sv
